// ----- rtl/lzw_pkg.sv -----
// Shared types and constants of the LZW encoder.
package lzw_pkg;

    // First code that names a dictionary entry; lower codes are single bytes
    localparam int unsigned FIRST_CODE = 256;
    localparam int unsigned BYTE_W     = 8;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_TAB,
        S_DICT,
        S_MISS,
        S_FLUSH
    } t_state;

endpackage

// ----- rtl/lzw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/lzw_fifo.sv -----
// Two-entry queue that decouples the producer and consumer of items.
module lzw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ----- rtl/lzw_core.sv -----
// Back end: hashed dictionary lookup, entry insert and code emission.
module lzw_core #(
    parameter int CODE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // queued input item: {end_of_message, data_byte}
    input  logic                 i_in_empty,
    input  logic [8:0]           i_in_data,
    output logic                 o_in_pop,
    // result queue: {dict_full, last, code}
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output logic [CODE_BITS+1:0] o_out_data
);
    import lzw_pkg::*;

    localparam int SLOT_W     = CODE_BITS + 1;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int DICT_DEPTH = (1 << CODE_BITS) - FIRST_CODE;
    localparam int DICT_AW    = $clog2(DICT_DEPTH);
    localparam int DICT_W     = SLOT_W + CODE_BITS + BYTE_W;
    localparam int NFC_W      = CODE_BITS + 1;
    localparam logic [NFC_W-1:0] FIRST_NFC = NFC_W'(FIRST_CODE);
    localparam logic [NFC_W-1:0] LIMIT_NFC = NFC_W'(1 << CODE_BITS);

    t_state                 r_state, n_state;
    logic [CODE_BITS-1:0]   r_pfx, n_pfx;
    logic                   r_pval, n_pval;
    logic                   r_full, n_full;
    logic [NFC_W-1:0]       r_nfc, n_nfc;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic                   r_eom, n_eom;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [CODE_BITS-1:0]   r_code, n_code;
    logic [SLOT_W-1:0]      r_clr, n_clr;

    logic [CODE_BITS-1:0]   w_tab_q;
    logic [DICT_W-1:0]      w_dict_q;
    logic                   w_tab_re;
    logic                   w_tab_we;
    logic [SLOT_W-1:0]      w_tab_waddr;
    logic [CODE_BITS-1:0]   w_tab_wdata;
    logic                   w_dict_re;
    logic                   w_dict_we;
    logic [DICT_AW-1:0]     w_dict_raddr;
    logic [DICT_AW-1:0]     w_dict_waddr;
    logic [SLOT_W-1:0]      w_hash;
    logic                   w_in_range;
    logic [SLOT_W-1:0]      w_q_slot;
    logic [CODE_BITS-1:0]   w_q_pfx;
    logic [BYTE_W-1:0]      w_q_byte;
    logic                   w_room;
    logic                   w_full_new;

    assign w_hash = {1'b0, r_pfx} ^ {i_in_data[7:0], {(SLOT_W-BYTE_W){1'b0}}};
    assign w_in_range = ({1'b0, w_tab_q} >= FIRST_NFC) && ({1'b0, w_tab_q} < r_nfc);
    assign {w_q_slot, w_q_pfx, w_q_byte} = w_dict_q;
    assign w_room = (r_nfc < LIMIT_NFC);
    assign w_full_new = r_full || !w_room;
    assign w_dict_raddr = DICT_AW'(w_tab_q - CODE_BITS'(FIRST_CODE));
    assign w_dict_waddr = DICT_AW'(r_nfc - FIRST_NFC);

    // Clearing pass writes empty slots; otherwise insert the next free code
    assign w_tab_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign w_tab_wdata = (r_state == S_CLEAR) ? '0 : r_nfc[CODE_BITS-1:0];

    // Hash slot table: slot -> code
    lzw_ram #(.WIDTH(CODE_BITS), .DEPTH(SLOTS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_tab_waddr),
        .i_wdata (w_tab_wdata),
        .i_re    (w_tab_re),
        .i_raddr (r_slot),
        .o_rdata (w_tab_q)
    );

    // Dictionary: code -> {owning slot, prefix, byte}
    lzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_DEPTH)) u_dict (
        .i_clk   (i_clk),
        .i_we    (w_dict_we),
        .i_waddr (w_dict_waddr),
        .i_wdata ({r_slot, r_pfx, r_byte}),
        .i_re    (w_dict_re),
        .i_raddr (w_dict_raddr),
        .o_rdata (w_dict_q)
    );

    // Next state and register updates
    always_comb begin
        n_state = r_state;
        n_pfx   = r_pfx;
        n_pval  = r_pval;
        n_full  = r_full;
        n_nfc   = r_nfc;
        n_byte  = r_byte;
        n_eom   = r_eom;
        n_slot  = r_slot;
        n_code  = r_code;
        n_clr   = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + SLOT_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_in_empty) begin
                    n_byte = i_in_data[7:0];
                    n_eom  = i_in_data[8];
                    if (!r_pval) begin
                        n_pfx   = CODE_BITS'(i_in_data[7:0]);
                        n_pval  = 1'b1;
                        n_state = i_in_data[8] ? S_FLUSH : S_IDLE;
                    end else begin
                        n_slot  = w_hash;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_state = S_TAB;
            end
            S_TAB: begin
                n_code  = w_tab_q;
                n_state = w_in_range ? S_DICT : S_MISS;
            end
            S_DICT: begin
                if (w_q_slot != r_slot) begin
                    // stale slot: treat as empty
                    n_state = S_MISS;
                end else if (w_q_pfx == r_pfx && w_q_byte == r_byte) begin
                    n_pfx   = r_code;
                    n_state = r_eom ? S_FLUSH : S_IDLE;
                end else begin
                    n_slot  = r_slot + SLOT_W'(1);
                    n_state = S_PROBE;
                end
            end
            S_MISS: begin
                if (!i_out_full) begin
                    if (w_room) begin
                        n_nfc = r_nfc + NFC_W'(1);
                    end else begin
                        n_full = 1'b1;
                    end
                    n_pfx   = CODE_BITS'(r_byte);
                    n_state = r_eom ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!i_out_full) begin
                    n_nfc   = FIRST_NFC;
                    n_pfx   = '0;
                    n_pval  = 1'b0;
                    n_full  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: memory strobes, queue pop and result push
    always_comb begin
        o_in_pop   = 1'b0;
        w_tab_re   = 1'b0;
        w_tab_we   = 1'b0;
        w_dict_re  = 1'b0;
        w_dict_we  = 1'b0;
        o_out_push = 1'b0;
        o_out_data = {r_full, 1'b0, r_pfx};
        case (r_state)
            S_CLEAR: w_tab_we = 1'b1;
            S_IDLE:  o_in_pop = !i_in_empty;
            S_PROBE: w_tab_re = 1'b1;
            S_TAB:   w_dict_re = w_in_range;
            S_MISS: begin
                o_out_push = !i_out_full;
                o_out_data = {w_full_new, 1'b0, r_pfx};
                w_tab_we   = !i_out_full && w_room;
                w_dict_we  = !i_out_full && w_room;
            end
            S_FLUSH: begin
                o_out_push = !i_out_full;
                o_out_data = {r_full, 1'b1, r_pfx};
            end
            default: o_in_pop = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pfx   <= '0;
            r_pval  <= 1'b0;
            r_full  <= 1'b0;
            r_nfc   <= FIRST_NFC;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_pfx   <= n_pfx;
            r_pval  <= n_pval;
            r_full  <= n_full;
            r_nfc   <= n_nfc;
            r_clr   <= n_clr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eom  <= n_eom;
        r_slot <= n_slot;
        r_code <= n_code;
    end
endmodule

// ----- rtl/lzw_encoder.sv -----
// Top level of the LZW encoder: input queue, lookup engine, result queue.
//
// Usage: send one message byte per item on the s_axis side (tdata[7:0]),
// with tlast high on the message's final byte. Codes come out on m_axis,
// one per item: tdata holds the code (CODE_BITS wide, zero-filled to whole
// bytes), tlast marks the flushed final code, tuser[0] is the sticky
// dictionary-full flag. The dictionary is cleared after each final byte.
// Sequence: a byte whose prefix is empty is handled in the idle state alone;
// otherwise a hit goes idle, probe, table read, dictionary check; a miss at
// an empty slot, or a stale one with an unused code, goes idle, probe, table
// read, miss; a miss at another stale slot adds the dictionary check before
// the miss. Each extra hash probe repeats probe, table read and dictionary
// check through the two registered-read tables. A final byte adds the flush
// state. The engine takes the next byte only once it is back in the idle state.
// Reset clears the queues and the encoder state, then walks all
// 2^(CODE_BITS+1) hash slots once before the first byte is looked up; stale
// slots of older messages are caught by checking each slot against the
// dictionary entry it names.
// When the receiver stalls, results wait in a two-entry queue and the engine
// holds a code to emit while that is full; the input queue takes items until full.
module lzw_encoder #(
    parameter int CODE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_byte
    input  logic                                s_axis_tlast,  // end_of_message
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // code
    output logic                                m_axis_tlast,  // last
    output logic                                m_axis_tuser   // dict_full
);
    import lzw_pkg::*;

    localparam int OUT_W  = CODE_BITS + 2;
    localparam int DATA_W = ((CODE_BITS + 7) / 8) * 8;

    logic             w_in_full;
    logic             w_in_empty;
    logic [8:0]       w_in_data;
    logic             w_in_pop;
    logic             w_out_full;
    logic             w_out_empty;
    logic             w_out_push;
    logic [OUT_W-1:0] w_out_wdata;
    logic [OUT_W-1:0] w_out_rdata;

    // Front: queue accepted bytes
    lzw_fifo #(.WIDTH(BYTE_W + 1)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  ({s_axis_tlast, s_axis_tdata}),
        .o_full  (w_in_full),
        .i_pop   (w_in_pop),
        .o_empty (w_in_empty),
        .o_data  (w_in_data)
    );

    assign s_axis_tready = !w_in_full;

    // Back: dictionary engine
    lzw_core #(.CODE_BITS(CODE_BITS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (w_in_empty),
        .i_in_data  (w_in_data),
        .o_in_pop   (w_in_pop),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_out_data (w_out_wdata)
    );

    // Result queue
    lzw_fifo #(.WIDTH(OUT_W)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_wdata),
        .o_full  (w_out_full),
        .i_pop   (m_axis_tready),
        .o_empty (w_out_empty),
        .o_data  (w_out_rdata)
    );

    assign m_axis_tvalid = !w_out_empty;
    assign m_axis_tdata  = DATA_W'(w_out_rdata[CODE_BITS-1:0]);
    assign m_axis_tlast  = w_out_rdata[CODE_BITS];
    assign m_axis_tuser  = w_out_rdata[CODE_BITS+1];
endmodule

// ----- dv/testbench.sv -----
// Self-checking LZW encoder testbench: directed and random traffic against a built-in predictor.
`timescale 1ns / 100ps

module testbench;
    import lzw_pkg::*;

    localparam int CODE_BITS = 12;
    localparam int CODE_LIMIT = 1 << CODE_BITS;
    localparam int TD_W = ((CODE_BITS + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 last;
        logic                 full;
    } t_code_item;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata = '0;   // data_byte
    logic            s_axis_tlast = 1'b0; // end_of_message
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [TD_W-1:0] m_axis_tdata;        // code
    logic            m_axis_tlast;        // last
    logic            m_axis_tuser;        // dict_full

    lzw_encoder #(.CODE_BITS(CODE_BITS)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: dictionary keyed by {prefix, byte} for a quick lookup
    int unsigned          dict_code [logic [CODE_BITS+7:0]];
    int unsigned          pred_next_free;
    logic [CODE_BITS-1:0] pred_prefix;
    bit                   pred_prefix_valid;
    bit                   pred_full;

    t_code_item expected_codes[$];
    int         error_count = 0;
    longint     cycle_count = 0;
    bit         hold_off = 1'b0;

    task automatic report(string what);
        error_count++;
        $display("testbench: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Work out the codes caused by one input byte
    task automatic predict_byte(logic [7:0] b, logic eom);
        logic [CODE_BITS+7:0] key;
        key = {pred_prefix, b};
        if (!pred_prefix_valid) begin
            pred_prefix = CODE_BITS'(b);
            pred_prefix_valid = 1'b1;
        end else if (dict_code.exists(key)) begin
            pred_prefix = CODE_BITS'(dict_code[key]);
        end else begin
            if (pred_next_free < CODE_LIMIT) begin
                dict_code[key] = pred_next_free;
                pred_next_free++;
            end else begin
                pred_full = 1'b1;
            end
            expected_codes.insert(expected_codes.size(),
                                  t_code_item'{pred_prefix, 1'b0, pred_full});
            pred_prefix = CODE_BITS'(b);
        end
        if (eom) begin
            expected_codes.insert(expected_codes.size(),
                                  t_code_item'{pred_prefix, 1'b1, pred_full});
            dict_code.delete();
            pred_next_free = FIRST_CODE;
            pred_prefix = '0;
            pred_prefix_valid = 1'b0;
            pred_full = 1'b0;
        end
    endtask

    // Send one item, with an optional random gap before it
    task automatic send_byte(logic [7:0] b, logic eom, bit gaps = 1'b1);
        int gap;
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, eom);
    endtask

    // Stop offering items and wait until every expected code has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
    endtask

    // Receiver readiness: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off || !i_rst_n)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 29) == 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each accepted code with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_codes.size() == 0) begin
                report($sformatf("unexpected code %0d", m_axis_tdata));
            end else begin
                t_code_item exp_item;
                exp_item = expected_codes.pop_front();
                if (m_axis_tdata !== TD_W'(exp_item.code))
                    report($sformatf("code %0d, expected %0d", m_axis_tdata, exp_item.code));
                if (m_axis_tlast !== exp_item.last)
                    report($sformatf("last %0b, expected %0b", m_axis_tlast, exp_item.last));
                if (m_axis_tuser !== exp_item.full)
                    report($sformatf("dict_full %0b, expected %0b", m_axis_tuser,
                                     exp_item.full));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Edge cases: single-byte message, empty-prefix start, byte extremes, repeats
    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++)
                    send_byte(8'($urandom_range(60, 63)), i == 29, 1'b0);
            end
        join
        wait_drained();
    endtask

    // Random messages, mostly short alphabets so prefixes grow long
    task automatic test_random(int total);
        int sent;
        int len;
        int span;
        sent = 0;
        while (sent < total) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            span = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, span)) ^ (span == 255 ? 8'h00 : 8'hC0),
                          i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        pred_next_free = FIRST_CODE;
        pred_prefix = '0;
        pred_prefix_valid = 1'b0;
        pred_full = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(800);
        test_backpressure();
        test_random(850);
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && expected_codes.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ----- lzw_encoder.f -----
rtl/lzw_pkg.sv
rtl/lzw_ram.sv
rtl/lzw_fifo.sv
rtl/lzw_core.sv
rtl/lzw_encoder.sv
dv/testbench.sv
